FILE: rtl/itp_pkg.sv
// Package for the infix to postfix converter: token and operator codes,
// stack sizing, precedence and pair-check functions, controller types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int ENTRY_W     = 5;
    localparam int TAG_W       = 32;

    typedef enum logic [2:0] {
        CLS_NUMBER   = 3'd0,
        CLS_VARIABLE = 3'd1,
        CLS_CALL     = 3'd2,
        CLS_LPAREN   = 3'd3,
        CLS_RPAREN   = 3'd4,
        CLS_OPERATOR = 3'd5
    } token_class_t;

    typedef enum logic [3:0] {
        OP_PLUS  = 4'd0,
        OP_SUB   = 4'd1,
        OP_MOD   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_LNOT  = 4'd5,
        OP_XOR   = 4'd6,
        OP_AND   = 4'd7,
        OP_OR    = 4'd8,
        OP_BNOT  = 4'd9,
        OP_SET   = 4'd10,
        OP_CAST  = 4'd11
    } op_code_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_SEQUENCE = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_code_t;

    // Source of a result loaded into the lookahead stage
    typedef enum logic [1:0] {
        SRC_OPERAND,
        SRC_POP,
        SRC_ERR_SEQ,
        SRC_ERR_OVF
    } src_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RPOP,
        ST_OPOP,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     produce;
        src_sel_t src;
        logic     pop;
        logic     push;
        logic     set_prev;
        logic     clear_stack;
        logic     end_expr;
        logic     set_skip;
        logic     finish;
    } itp_cmd_t;

    typedef struct packed {
        logic       skipping;
        logic       illegal;
        logic [2:0] tok_class;
        logic       tok_end;
        logic       count_zero;
        logic       full;
        logic       top_lparen;
        logic       prec_ok;
        logic       slot_ok;
        logic       out_free;
        logic       hold_valid;
    } itp_status_t;

    function automatic logic signed [3:0] prec_of(input logic [3:0] op);
        logic signed [3:0] p;
        case (op) inside
            OP_BNOT:                p = 4'sd5;
            OP_CAST:                p = 4'sd4;
            OP_MOD, OP_MUL, OP_DIV: p = 4'sd3;
            OP_PLUS, OP_SUB:        p = 4'sd2;
            OP_XOR, OP_AND, OP_OR:  p = 4'sd1;
            OP_SET:                 p = 4'sd0;
            default:                p = -4'sd1;
        endcase
        return p;
    endfunction

    function automatic logic pair_legal(input logic [2:0] prev, input logic [2:0] cur);
        logic ok;
        case (prev) inside
            CLS_NUMBER, CLS_VARIABLE, CLS_CALL, CLS_RPAREN:
                ok = (cur == CLS_RPAREN) || (cur == CLS_OPERATOR);
            CLS_LPAREN, CLS_OPERATOR:
                ok = (cur inside {CLS_NUMBER, CLS_VARIABLE, CLS_CALL, CLS_LPAREN});
            default:
                ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/infix_to_postfix_converter_top.sv
// Top level of the infix to postfix converter (shunting-yard).
// Joins itp_ctrl and itp_datapath; uses itp_pkg.
//
//  port   | dir | tdata, low bits up          | tuser, low bits up                | tlast
//  s_axis | in  | [3:0] op, [35:4] tag, pad   | [2:0] token_class                 | expression_end
//  m_axis | out | [3:0] op, [35:4] tag, pad   | [2:0] class, [4:3] err, [5] done  | last_of_run
//
// A token is accepted in ST_IDLE and evaluated in ST_EVAL; a token skipped after an error ends there.
// An operand, a left paren or an error found on evaluation then goes on to the hand-off state, ST_FINISH.
// Right paren and operator pop entries in ST_RPOP or ST_OPOP, one entry at a time, before hand-off;
// an end mark also flushes every stack entry, one at a time, in ST_FLUSH.
// Reset clears the stack count and expression state; stack contents are not reset.
// A stalled m_axis holds up pops and hand-off once output register and lookahead are full.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_top
    import itp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // operator_code, operand_tag, pad
    input  wire logic [2:0]  s_axis_tuser,   // token_class
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // out_operator, out_operand, pad
    output logic [5:0]       m_axis_tuser,   // out_class, error_code, expression_done
    output logic             m_axis_tlast
);

    itp_cmd_t    cmd;
    itp_status_t sts;

    itp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    itp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .sts           (sts)
    );

    // a new token never arrives with a result still in the lookahead
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !sts.hold_valid)
        else $error("token accepted with lookahead full");

    // a result is only made when there is room to move the previous one on
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.produce |-> sts.slot_ok)
        else $error("result produced without a free slot");

    // an error beat closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[4:3] != ERR_NONE)) |-> m_axis_tlast)
        else $error("error beat not last of run");

    // expression done only on the last beat of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[5]) |-> m_axis_tlast)
        else $error("expression done without last");

endmodule

`default_nettype wire

FILE: rtl/itp_ctrl.sv
// Controller state machine for the infix to postfix converter.
// Sequences evaluation, pop loops, flush and result hand-off. Uses itp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itp_ctrl
    import itp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire itp_status_t sts,
    output itp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.src       = SRC_OPERAND;
        s_axis_tready = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                // lookahead stage is always empty here, so a result can be made
                if (sts.skipping)
                begin
                    cmd.end_expr = sts.tok_end;
                    state_next   = ST_IDLE;
                end
                else if (sts.illegal)
                begin
                    cmd.produce     = 1'b1;
                    cmd.src         = SRC_ERR_SEQ;
                    cmd.clear_stack = 1'b1;
                    cmd.end_expr    = sts.tok_end;
                    cmd.set_skip    = !sts.tok_end;
                    state_next      = ST_FINISH;
                end
                else if (sts.tok_class inside {CLS_NUMBER, CLS_VARIABLE, CLS_CALL})
                begin
                    cmd.produce  = 1'b1;
                    cmd.src      = SRC_OPERAND;
                    cmd.set_prev = 1'b1;
                    state_next   = sts.tok_end ? ST_FLUSH : ST_FINISH;
                end
                else if (sts.tok_class == CLS_LPAREN)
                begin
                    if (sts.full)
                    begin
                        cmd.produce     = 1'b1;
                        cmd.src         = SRC_ERR_OVF;
                        cmd.clear_stack = 1'b1;
                        cmd.end_expr    = sts.tok_end;
                        cmd.set_skip    = !sts.tok_end;
                        state_next      = ST_FINISH;
                    end
                    else
                    begin
                        cmd.push     = 1'b1;
                        cmd.set_prev = 1'b1;
                        state_next   = sts.tok_end ? ST_FLUSH : ST_FINISH;
                    end
                end
                else if (sts.tok_class == CLS_RPAREN)
                begin
                    state_next = ST_RPOP;
                end
                else
                begin
                    state_next = ST_OPOP;
                end
            end

            ST_RPOP:
            begin
                if (!sts.count_zero && !sts.top_lparen)
                begin
                    if (sts.slot_ok)
                    begin
                        cmd.produce = 1'b1;
                        cmd.src     = SRC_POP;
                    end
                end
                else
                begin
                    // drop the matching left paren, if any
                    cmd.pop      = !sts.count_zero;
                    cmd.set_prev = 1'b1;
                    state_next   = sts.tok_end ? ST_FLUSH : ST_FINISH;
                end
            end

            ST_OPOP:
            begin
                if (!sts.count_zero && !sts.top_lparen && sts.prec_ok)
                begin
                    if (sts.slot_ok)
                    begin
                        cmd.produce = 1'b1;
                        cmd.src     = SRC_POP;
                    end
                end
                else if (sts.full)
                begin
                    if (sts.slot_ok)
                    begin
                        cmd.produce     = 1'b1;
                        cmd.src         = SRC_ERR_OVF;
                        cmd.clear_stack = 1'b1;
                        cmd.end_expr    = sts.tok_end;
                        cmd.set_skip    = !sts.tok_end;
                        state_next      = ST_FINISH;
                    end
                end
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.set_prev = 1'b1;
                    state_next   = sts.tok_end ? ST_FLUSH : ST_FINISH;
                end
            end

            ST_FLUSH:
            begin
                if (!sts.count_zero)
                begin
                    if (sts.slot_ok)
                    begin
                        cmd.produce = 1'b1;
                        cmd.src     = SRC_POP;
                    end
                end
                else
                begin
                    cmd.end_expr = 1'b1;
                    state_next   = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!sts.hold_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/itp_datapath.sv
// Datapath for the infix to postfix converter: token register, operator
// stack, expression state, one-result lookahead and output register. Uses itp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itp_datapath
    import itp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic [2:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,
    output logic [5:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire itp_cmd_t    cmd,
    output itp_status_t      sts
);

    // token register
    logic [2:0]       tok_class_reg;
    logic [3:0]       tok_op_reg;
    logic [TAG_W-1:0] tok_tag_reg;
    logic             tok_end_reg;

    // expression state
    logic [ENTRY_W-1:0] stack_reg [STACK_DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [2:0]         prev_reg;
    logic [2:0]         prev_next;
    logic               skip_reg;
    logic               skip_next;

    // lookahead and output stage
    logic             hold_valid_reg;
    logic             hold_valid_next;
    logic [2:0]       hold_class_reg;
    logic [3:0]       hold_op_reg;
    logic [TAG_W-1:0] hold_tag_reg;
    logic [1:0]       hold_err_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [2:0]       out_class_reg;
    logic [3:0]       out_op_reg;
    logic [TAG_W-1:0] out_tag_reg;
    logic [1:0]       out_err_reg;
    logic             out_done_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0]   count_m1;
    logic [IDX_W-1:0]   top_idx;
    logic [IDX_W-1:0]   push_idx;
    logic [ENTRY_W-1:0] top_entry;
    logic [ENTRY_W-1:0] push_entry;
    logic               do_pop;
    logic               out_free;
    logic               out_load;
    logic [2:0]         new_class;
    logic [3:0]         new_op;
    logic [TAG_W-1:0]   new_tag;
    logic [1:0]         new_err;

    assign count_m1   = count_reg - CNT_W'(1);
    assign top_idx    = count_m1[IDX_W-1:0];
    assign push_idx   = count_reg[IDX_W-1:0];
    assign top_entry  = stack_reg[top_idx];
    assign push_entry = (tok_class_reg == CLS_LPAREN) ? {1'b1, 4'd0} : {1'b0, tok_op_reg};
    assign do_pop     = cmd.pop || (cmd.produce && (cmd.src == SRC_POP));
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign out_load   = (cmd.produce && hold_valid_reg) || cmd.finish;

    always_comb
    begin
        sts.skipping   = skip_reg;
        sts.illegal    = !pair_legal(prev_reg, tok_class_reg)
                         || ((tok_class_reg == CLS_OPERATOR) && (tok_op_reg > OP_CAST));
        sts.tok_class  = tok_class_reg;
        sts.tok_end    = tok_end_reg;
        sts.count_zero = (count_reg == '0);
        sts.full       = (count_reg == CNT_W'(STACK_DEPTH));
        sts.top_lparen = top_entry[ENTRY_W-1];
        sts.prec_ok    = prec_of(tok_op_reg) <= prec_of(top_entry[3:0]);
        sts.slot_ok    = !hold_valid_reg || out_free;
        sts.out_free   = out_free;
        sts.hold_valid = hold_valid_reg;
    end

    // result selection
    always_comb
    begin
        new_class = CLS_NUMBER;
        new_op    = '0;
        new_tag   = '0;
        new_err   = ERR_NONE;
        case (cmd.src)
            SRC_OPERAND:
            begin
                new_class = tok_class_reg;
                new_tag   = tok_tag_reg;
            end
            SRC_POP:
            begin
                if (top_entry[ENTRY_W-1])
                begin
                    new_class = CLS_LPAREN;
                end
                else
                begin
                    new_class = CLS_OPERATOR;
                    new_op    = top_entry[3:0];
                end
            end
            SRC_ERR_SEQ:
            begin
                new_err = ERR_SEQUENCE;
            end
            SRC_ERR_OVF:
            begin
                new_err = ERR_OVERFLOW;
            end
            default:
            begin
                new_err = ERR_NONE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_stack || cmd.end_expr)
        begin
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop)
        begin
            count_next = count_m1;
        end

        prev_next = prev_reg;
        if (cmd.end_expr)
        begin
            prev_next = CLS_OPERATOR;
        end
        else if (cmd.set_prev)
        begin
            prev_next = tok_class_reg;
        end

        skip_next = skip_reg;
        if (cmd.end_expr)
        begin
            skip_next = 1'b0;
        end
        else if (cmd.set_skip)
        begin
            skip_next = 1'b1;
        end

        hold_valid_next = hold_valid_reg;
        if (cmd.produce)
        begin
            hold_valid_next = 1'b1;
        end
        else if (cmd.finish)
        begin
            hold_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            prev_reg       <= CLS_OPERATOR;
            skip_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            prev_reg       <= prev_next;
            skip_reg       <= skip_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tok_op_reg    <= s_axis_tdata[3:0];
            tok_tag_reg   <= s_axis_tdata[35:4];
            tok_class_reg <= s_axis_tuser;
            tok_end_reg   <= s_axis_tlast;
        end
        if (cmd.push)
        begin
            stack_reg[push_idx] <= push_entry;
        end
        if (cmd.produce)
        begin
            hold_class_reg <= new_class;
            hold_op_reg    <= new_op;
            hold_tag_reg   <= new_tag;
            hold_err_reg   <= new_err;
        end
        if (out_load)
        begin
            out_class_reg <= hold_class_reg;
            out_op_reg    <= hold_op_reg;
            out_tag_reg   <= hold_tag_reg;
            out_err_reg   <= hold_err_reg;
            out_last_reg  <= cmd.finish;
            out_done_reg  <= cmd.finish && tok_end_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_tag_reg, out_op_reg};
    assign m_axis_tuser  = {out_done_reg, out_err_reg, out_class_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: tb/sv/infix_to_postfix_converter_top_tb.sv
// Self-checking testbench for infix_to_postfix_converter_top: drives token beats on s_axis,
// predicts the postfix stream with its own operator stack and checks every m_axis beat.
// Depends on itp_pkg and the RTL top level only.
`timescale 1ns / 1ps

module infix_to_postfix_converter_top_tb;
    import itp_pkg::*;

    // classes and operator codes outside the legal range, and the stack entry of a left parenthesis
    localparam logic [2:0] CLS_BAD_LO   = 3'd6;
    localparam logic [2:0] CLS_BAD_HI   = 3'd7;
    localparam logic [3:0] OP_BAD_TOP   = 4'd15;
    localparam logic [4:0] LPAREN_ENTRY = 5'h10;

    typedef struct {
        logic [2:0]  cls;
        logic [3:0]  opc;
        logic [31:0] tag;
        logic        eoe;
    } token_t;

    typedef struct {
        logic [2:0]  rclass;
        logic [3:0]  rop;
        logic [31:0] roperand;
        logic [1:0]  rerr;
        logic        rdone;
        logic        rlast;
    } result_t;

    class postfix_scoreboard;
        logic [4:0] op_stack [STACK_DEPTH];
        int         depth;
        logic [2:0] prev_cls;
        bit         skip;
        result_t    expected_beats [$];
        int         fails;

        function new();
            depth    = 0;
            prev_cls = CLS_OPERATOR;
            skip     = 0;
            fails    = 0;
        endfunction

        function int precedence(logic [3:0] op);
            case (op)
                OP_BNOT:                return 5;
                OP_CAST:                return 4;
                OP_MOD, OP_MUL, OP_DIV: return 3;
                OP_PLUS, OP_SUB:        return 2;
                OP_XOR, OP_AND, OP_OR:  return 1;
                OP_SET:                 return 0;
                default:                return -1;
            endcase
        endfunction

        function bit pair_ok(logic [2:0] prev, logic [2:0] cur);
            if (prev <= CLS_CALL || prev == CLS_RPAREN)
                return cur == CLS_RPAREN || cur == CLS_OPERATOR;
            if (prev == CLS_LPAREN || prev == CLS_OPERATOR)
                return cur <= CLS_CALL || cur == CLS_LPAREN;
            return 0;
        endfunction

        function result_t beat_of(logic [2:0] c, logic [3:0] o, logic [31:0] v, logic [1:0] e);
            result_t r;
            r.rclass   = c;
            r.rop      = o;
            r.roperand = v;
            r.rerr     = e;
            r.rdone    = 1'b0;
            r.rlast    = 1'b0;
            return r;
        endfunction

        function result_t pop_entry();
            logic [4:0] e;
            depth = depth - 1;
            e     = op_stack[depth];
            if (e & LPAREN_ENTRY)
                return beat_of(CLS_LPAREN, 4'd0, 32'd0, ERR_NONE);
            return beat_of(CLS_OPERATOR, e[3:0], 32'd0, ERR_NONE);
        endfunction

        function void clear_expr();
            depth    = 0;
            prev_cls = CLS_OPERATOR;
            skip     = 0;
        endfunction

        // work out the beats one accepted token causes and queue them
        function void note_token(token_t t);
            result_t    run [$];
            result_t    r;
            logic [1:0] code;
            int         p;
            if (skip)
            begin
                if (t.eoe)
                    clear_expr();
                return;
            end
            code = ERR_NONE;
            if (!pair_ok(prev_cls, t.cls) || (t.cls == CLS_OPERATOR && t.opc > OP_CAST))
            begin
                code = ERR_SEQUENCE;
            end
            else if (t.cls <= CLS_CALL)
            begin
                run.push_back(beat_of(t.cls, 4'd0, t.tag, ERR_NONE));
            end
            else if (t.cls == CLS_LPAREN)
            begin
                if (depth >= STACK_DEPTH)
                    code = ERR_OVERFLOW;
                else
                begin
                    op_stack[depth] = LPAREN_ENTRY;
                    depth = depth + 1;
                end
            end
            else if (t.cls == CLS_RPAREN)
            begin
                while (depth > 0 && !(op_stack[depth-1] & LPAREN_ENTRY))
                    run.push_back(pop_entry());
                if (depth > 0)
                    depth = depth - 1;
            end
            else
            begin
                p = precedence(t.opc);
                // never pops past a left parenthesis
                while (depth > 0 && !(op_stack[depth-1] & LPAREN_ENTRY) &&
                       p <= precedence(op_stack[depth-1][3:0]))
                    run.push_back(pop_entry());
                if (depth >= STACK_DEPTH)
                    code = ERR_OVERFLOW;
                else
                begin
                    op_stack[depth] = {1'b0, t.opc};
                    depth = depth + 1;
                end
            end

            if (code != ERR_NONE)
            begin
                r = beat_of(CLS_NUMBER, 4'd0, 32'd0, code);
                depth = 0;
                if (t.eoe)
                begin
                    r.rdone = 1'b1;
                    clear_expr();
                end
                else
                    skip = 1;
                r.rlast = 1'b1;
                run.push_back(r);
            end
            else
            begin
                prev_cls = t.cls;
                if (t.eoe)
                begin
                    while (depth > 0)
                        run.push_back(pop_entry());
                    clear_expr();
                end
                if (run.size() > 0)
                begin
                    r = run.pop_back();
                    r.rdone = t.eoe;
                    r.rlast = 1'b1;
                    run.push_back(r);
                end
            end
            foreach (run[i])
                expected_beats.push_back(run[i]);
        endfunction

        function void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", fname, want, got);
                fails++;
            end
        endfunction

        function void check_beat(result_t got);
            result_t want;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: class %0d operand %0h", got.rclass, got.roperand);
                fails++;
                return;
            end
            want = expected_beats.pop_front();
            cmp_field("out_class", 32'(want.rclass), 32'(got.rclass));
            cmp_field("out_operator", 32'(want.rop), 32'(got.rop));
            cmp_field("out_operand", want.roperand, got.roperand);
            cmp_field("error_code", 32'(want.rerr), 32'(got.rerr));
            cmp_field("expression_done", 32'(want.rdone), 32'(got.rdone));
            cmp_field("last_of_run", 32'(want.rlast), 32'(got.rlast));
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [5:0]  m_axis_tuser;
    logic        m_axis_tlast;

    postfix_scoreboard sb;
    token_t            token_queue [$];
    int                src_idle_pct  = 0;
    int                sink_stall_pct = 0;
    int                sink_hold     = 0;
    bit                deep_next     = 0;

    infix_to_postfix_converter_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // receiver: samples beats at the edge, then picks ready for the next cycle
    initial
    begin
        result_t r;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready && rst_n)
            begin
                r.rclass   = m_axis_tuser[2:0];
                r.rerr     = m_axis_tuser[4:3];
                r.rdone    = m_axis_tuser[5];
                r.rop      = m_axis_tdata[3:0];
                r.roperand = m_axis_tdata[35:4];
                r.rlast    = m_axis_tlast;
                sb.check_beat(r);
            end
            if (sink_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold = sink_hold - 1;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic token_t tok(logic [2:0] c, logic [3:0] o, logic [31:0] v, logic e);
        token_t t;
        t.cls = c;
        t.opc = o;
        t.tag = v;
        t.eoe = e;
        return t;
    endfunction

    function automatic token_t rand_operand();
        return tok(3'($urandom_range(CLS_CALL)), 4'($urandom_range(15)), $urandom, 1'b0);
    endfunction

    // one expression: mostly well formed, some corrupted, some plain noise
    function automatic void build_expression();
        token_t expr [$];
        token_t t;
        int     mode;
        int     open_cnt;
        int     max_len;
        int     lp_pct;
        int     open_max;
        bit     want_operand;
        int     n;
        mode = $urandom_range(99);
        if (deep_next)
            mode = 99;
        if (mode < 12)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                expr.push_back(tok(3'($urandom_range(7)), 4'($urandom_range(15)), $urandom,
                                   i == n - 1 || $urandom_range(99) < 10));
        end
        else
        begin
            open_cnt     = 0;
            want_operand = 1;
            if (mode >= 90)
            begin
                max_len  = $urandom_range(20, 40);
                lp_pct   = deep_next ? 100 : 70;
                open_max = 20;
            end
            else
            begin
                max_len  = $urandom_range(1, 14);
                lp_pct   = 20;
                open_max = 4;
            end
            deep_next = 0;
            while (1)
            begin
                if (want_operand)
                begin
                    if (open_cnt < open_max && $urandom_range(99) < lp_pct)
                    begin
                        expr.push_back(tok(CLS_LPAREN, 4'($urandom_range(15)), $urandom, 1'b0));
                        open_cnt++;
                    end
                    else
                    begin
                        expr.push_back(rand_operand());
                        want_operand = 0;
                    end
                end
                else if (expr.size() >= max_len &&
                         (open_cnt == 0 || $urandom_range(99) < 5))
                begin
                    break;
                end
                else if (open_cnt > 0 &&
                         (expr.size() >= max_len || $urandom_range(99) < 35))
                begin
                    expr.push_back(tok(CLS_RPAREN, 4'($urandom_range(15)), $urandom, 1'b0));
                    open_cnt--;
                end
                else if (open_cnt == 0 && $urandom_range(99) < 3)
                begin
                    // stray right parenthesis
                    expr.push_back(tok(CLS_RPAREN, 4'($urandom_range(15)), $urandom, 1'b0));
                end
                else
                begin
                    expr.push_back(tok(CLS_OPERATOR, 4'($urandom_range(OP_CAST)), $urandom,
                                       1'b0));
                    want_operand = 1;
                end
            end
            t = expr.pop_back();
            t.eoe = 1'b1;
            expr.push_back(t);
            if (mode < 20)
            begin
                n = $urandom_range(expr.size() - 1);
                expr[n].cls = 3'($urandom_range(7));
                expr[n].opc = 4'($urandom_range(15));
            end
        end
        foreach (expr[i])
            token_queue.push_back(expr[i]);
    endfunction

    task automatic send_token(input token_t t);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, t.tag, t.opc};
        s_axis_tuser  <= t.cls;
        s_axis_tlast  <= t.eoe;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_token(t);
    endtask

    task automatic run_phase(input int n_items, input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (token_queue.size() == 0)
                build_expression();
            send_token(token_queue.pop_front());
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_beats.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every operator in one expression, field extremes on the operands
        token_queue.push_back(tok(CLS_VARIABLE, 4'd0, 32'hFFFF_FFFF, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_PLUS, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_NUMBER, 4'd0, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_MUL, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_CALL, OP_BAD_TOP, 32'h1234_5678, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_SUB, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_NUMBER, 4'd0, 32'h8000_0001, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_DIV, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_VARIABLE, 4'd0, 32'h0000_00A5, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_MOD, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_NUMBER, 4'd0, 32'd3, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_XOR, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_NUMBER, 4'd0, 32'd4, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_AND, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_NUMBER, 4'd0, 32'd5, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_OR, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_NUMBER, 4'd0, 32'd6, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_SET, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_NUMBER, 4'd0, 32'd7, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_CAST, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_NUMBER, 4'd0, 32'd8, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_BNOT, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_NUMBER, 4'd0, 32'd9, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_LNOT, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_NUMBER, 4'd0, 32'd10, 1'b1));
        // unmatched left parenthesis comes out on the flush
        token_queue.push_back(tok(CLS_LPAREN, 4'd0, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_VARIABLE, 4'd0, 32'd11, 1'b1));
        // stray right parenthesis on the end mark: nothing emitted, no done flag
        token_queue.push_back(tok(CLS_VARIABLE, 4'd0, 32'd12, 1'b0));
        token_queue.push_back(tok(CLS_RPAREN, 4'd0, 32'd0, 1'b1));
        // unknown class
        token_queue.push_back(tok(CLS_BAD_HI, 4'd0, 32'd0, 1'b1));
        // bad operator code mid-expression, rest skipped
        token_queue.push_back(tok(CLS_NUMBER, 4'd0, 32'd13, 1'b0));
        token_queue.push_back(tok(CLS_OPERATOR, OP_BAD_TOP, 32'd0, 1'b0));
        token_queue.push_back(tok(CLS_NUMBER, 4'd0, 32'd14, 1'b1));
        // prefix operator at the start is illegal
        token_queue.push_back(tok(CLS_OPERATOR, OP_LNOT, 32'd0, 1'b1));
        token_queue.push_back(tok(CLS_BAD_LO, 4'd0, 32'd0, 1'b1));
        run_phase(token_queue.size(), 0, 0);

        deep_next = 1;  // first random expression overflows the stack
        run_phase(110, 0, 0);
        run_phase(90, 85, 0);
        run_phase(100, 0, 85);
        run_phase(100, 21, 21);

        // sender waits for every beat, then the receiver holds off while beats pile up
        drain();
        sink_hold = 300;
        run_phase(40, 0, 0);

        drain();
        repeat (40) @(posedge clk);
        if (sb.fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
